[hw/rtl/scc_pkg.sv]
// shared types, constants and helpers of the snooping cache coherence controller
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

	// cache geometry
	localparam int SETS        = 64;
	localparam int WAYS        = 2;
	localparam int LINE_BYTES  = 32;
	localparam int WORD_BYTES  = 4;

	localparam int ADDR_BITS   = 32;
	localparam int STAMP_BITS  = 32;
	localparam int OFFSET_BITS = $clog2(LINE_BYTES);
	localparam int SET_BITS    = $clog2(SETS);
	localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;
	localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

	// result list of one request
	localparam int MAX_RESULTS  = 3;
	localparam int RES_IDX_BITS = $clog2(MAX_RESULTS);
	localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

	// bus cost
	localparam int COST_BITS      = 7;
	localparam int BUS_BASE_RAW   = 100;
	localparam int UPD_RAW        = (LINE_BYTES / WORD_BYTES) * 2;
	localparam int UPD_SAT        = (UPD_RAW > 127) ? 127 : UPD_RAW;
	localparam logic [COST_BITS-1:0] BUS_BASE_CYCLES = COST_BITS'(BUS_BASE_RAW);
	localparam logic [COST_BITS-1:0] UPD_CYCLES      = COST_BITS'(UPD_SAT);

	// configuration
	localparam int CORE_BITS     = 2;
	localparam int CFG_DATA_BITS = CORE_BITS;

	typedef enum logic [0:0] {
		CFG_PROTOCOL = 1'b0,
		CFG_CORE     = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		PROTO_MESI   = 1'b0,
		PROTO_DRAGON = 1'b1
	} proto_t;

	// event codes of the func field
	typedef enum logic [2:0] {
		EV_PR_RD   = 3'd0,
		EV_PR_WR   = 3'd1,
		EV_BUS_RD  = 3'd2,
		EV_BUS_RDX = 3'd3,
		EV_BUS_UPD = 3'd4
	} ev_t;

	// line states of both protocols
	typedef enum logic [2:0] {
		COH_I  = 3'd0,
		COH_S  = 3'd1,
		COH_M  = 3'd2,
		COH_E  = 3'd3,
		COH_SC = 3'd4,
		COH_SM = 3'd5
	} coh_t;

	typedef enum logic [2:0] {
		REQ_NONE  = 3'd0,
		REQ_RD    = 3'd1,
		REQ_RDX   = 3'd2,
		REQ_UPD   = 3'd3,
		REQ_FLUSH = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		CLS_PRIVATE = 2'd0,
		CLS_SHARED  = 2'd1,
		CLS_NONE    = 2'd2
	} cls_t;

	typedef enum logic [0:0] {
		FSM_IDLE = 1'b0,
		FSM_CALC = 1'b1
	} fsm_t;

	// one way of a set, as kept in the line store
	typedef struct packed {
		logic [TAG_BITS-1:0]   tag;
		coh_t                  coh;
		logic [STAMP_BITS-1:0] stamp;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	// registered request, address already split
	typedef struct packed {
		logic [2:0]            func;
		logic [TAG_BITS-1:0]   tag;
		logic [SET_BITS-1:0]   set;
		logic                  shared;
		logic [STAMP_BITS-1:0] now;
	} item_t;

	typedef struct packed {
		logic                en;
		logic [SET_BITS-1:0] set;
	} store_rd_t;

	typedef struct packed {
		logic                en;
		logic [SET_BITS-1:0] set;
		row_t                row;
	} store_wr_t;

	// everything the result queue needs for one request
	typedef struct packed {
		logic                                   hit;
		cls_t                                   cls;
		logic                                   err;
		logic [CORE_BITS-1:0]                   core;
		logic [RES_CNT_BITS-1:0]                cnt;
		req_t [MAX_RESULTS-1:0]                 req;
		logic [MAX_RESULTS-1:0][ADDR_BITS-1:0]  addr;
	} result_set_t;

	function automatic logic [COST_BITS-1:0] cost_of(input req_t q);
		logic [COST_BITS-1:0] c;
		unique case (q)
			REQ_NONE: c = '0;
			REQ_UPD:  c = UPD_CYCLES;
			default:  c = BUS_BASE_CYCLES;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/scc_if.sv]
// request and result channels of the coherence controller
`timescale 1ns / 1ps
`default_nettype none

interface scc_in_if;
	import scc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [2:0]            func;
	logic [ADDR_BITS-1:0]  address;
	logic                  shared_line;
	logic [STAMP_BITS-1:0] now_time;

	modport source (output valid, func, address, shared_line, now_time, input ready);
	modport sink   (input valid, func, address, shared_line, now_time, output ready);
endinterface

interface scc_out_if;
	import scc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [1:0]           access_class;
	logic                 error;
	logic [2:0]           bus_request;
	logic [ADDR_BITS-1:0] bus_address;
	logic [COST_BITS-1:0] bus_cycles;
	logic [CORE_BITS-1:0] request_core;
	logic                 last;

	modport source (output valid, hit, access_class, error, bus_request, bus_address,
		bus_cycles, request_core, last, input ready);
	modport sink   (input valid, hit, access_class, error, bus_request, bus_address,
		bus_cycles, request_core, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/scc_line_store.sv]
// set memory holding tag, state and stamp of every way, with per-set valid bits
`timescale 1ns / 1ps
`default_nettype none

module scc_line_store (
	input  logic               clk,
	input  logic               arst_n,
	input  scc_pkg::store_rd_t rd,
	input  scc_pkg::store_wr_t wr,
	output scc_pkg::row_t      rdata
);
	import scc_pkg::*;

	row_t            mem [SETS];
	logic [SETS-1:0] row_valid_q;
	row_t            rdata_q;
	logic            rvalid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.set] <= wr.row;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				row_valid_q[wr.set] <= 1'b1;
			end
			if (rd.en) begin
				rvalid_q <= row_valid_q[rd.set];
			end
		end
	end

	// a set never written reads as all ways invalid
	always_comb begin
		rdata = rdata_q;
		if (!rvalid_q) begin
			for (int w = 0; w < WAYS; w++) begin
				rdata[w].coh = COH_I;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/scc_update.sv]
// lookup, victim choice and MESI / Dragon transition for one set
`timescale 1ns / 1ps
`default_nettype none

module scc_update (
	input  scc_pkg::item_t                  item,
	input  scc_pkg::row_t                   row,
	input  scc_pkg::proto_t                 proto,
	input  logic [scc_pkg::CORE_BITS-1:0]   core,
	output scc_pkg::row_t                   row_new,
	output scc_pkg::result_set_t            res
);
	import scc_pkg::*;

	logic                    hit_any;
	logic [WAY_BITS-1:0]     hit_way;
	logic                    inv_any;
	logic [WAY_BITS-1:0]     inv_way;
	logic [WAY_BITS-1:0]     old_way;
	logic [STAMP_BITS-1:0]   old_stamp;
	logic [WAY_BITS-1:0]     vic_way;
	logic [WAY_BITS-1:0]     tgt;
	logic                    is_pr;
	logic                    is_rd;
	logic                    is_wr;
	logic                    is_snoop;
	logic                    step;
	logic                    flush;
	logic [ADDR_BITS-1:0]    flush_addr;
	logic [ADDR_BITS-1:0]    line_addr;
	coh_t                    st;
	coh_t                    nst;
	cls_t                    cls;
	logic                    err;
	logic                    stamp_we;
	req_t                    r0;
	req_t                    r1;
	logic [RES_CNT_BITS-1:0] n;

	// way search: first valid match, first invalid way, oldest stamp
	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		inv_any = 1'b0;
		inv_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w].coh != COH_I && row[w].tag == item.tag) begin
				hit_any = 1'b1;
				hit_way = WAY_BITS'(w);
			end
			if (row[w].coh == COH_I) begin
				inv_any = 1'b1;
				inv_way = WAY_BITS'(w);
			end
		end
		old_way   = '0;
		old_stamp = row[0].stamp;
		for (int w = 1; w < WAYS; w++) begin
			if (row[w].stamp < old_stamp) begin
				old_stamp = row[w].stamp;
				old_way   = WAY_BITS'(w);
			end
		end
		vic_way = inv_any ? inv_way : old_way;
	end

	always_comb begin
		is_rd    = item.func == EV_PR_RD;
		is_wr    = item.func == EV_PR_WR;
		is_pr    = is_rd || is_wr;
		is_snoop = item.func == EV_BUS_RD || item.func == EV_BUS_RDX
			|| item.func == EV_BUS_UPD;
		line_addr = {item.tag, item.set, {OFFSET_BITS{1'b0}}};

		row_new    = row;
		flush      = 1'b0;
		flush_addr = '0;
		tgt        = hit_any ? hit_way : vic_way;
		st         = row[tgt].coh;

		// processor miss: evict the victim and install the new tag
		if (is_pr && !hit_any) begin
			if (row[vic_way].coh != COH_I) begin
				flush      = 1'b1;
				flush_addr = {row[vic_way].tag, item.set, {OFFSET_BITS{1'b0}}};
			end
			st                   = COH_I;
			row_new[vic_way].tag = item.tag;
			row_new[vic_way].coh = COH_I;
		end

		step     = is_pr || (is_snoop && hit_any);
		nst      = st;
		cls      = CLS_NONE;
		err      = 1'b0;
		stamp_we = 1'b0;
		r0       = REQ_NONE;
		r1       = REQ_NONE;

		if (!is_pr && !is_snoop) begin
			err = 1'b1;
		end else if (step && proto == PROTO_MESI) begin
			if (!(st == COH_I || st == COH_S || st == COH_M || st == COH_E)) begin
				err = 1'b1;
			end else if (is_pr) begin
				stamp_we = 1'b1;
				priority if (st == COH_I) begin
					if (is_rd) begin
						r0  = REQ_RD;
						nst = item.shared ? COH_S : COH_E;
						cls = item.shared ? CLS_SHARED : CLS_PRIVATE;
					end else begin
						r0  = REQ_RDX;
						nst = COH_M;
						cls = CLS_PRIVATE;
					end
				end else if (st == COH_S) begin
					if (is_wr) begin
						r0  = REQ_RDX;
						nst = COH_M;
					end
					cls = CLS_SHARED;
				end else begin
					if (is_wr) begin
						nst = COH_M;
					end
					cls = CLS_PRIVATE;
				end
			end else if (st != COH_I) begin
				priority if (item.func == EV_BUS_RD) begin
					nst = COH_S;
				end else if (item.func == EV_BUS_RDX) begin
					nst = COH_I;
				end else if (st == COH_S) begin
					// upgrade seen on a shared line is illegal under MESI
					err = 1'b1;
				end
			end
		end else if (step) begin
			if (!(st == COH_I || st == COH_M || st == COH_E || st == COH_SC
				|| st == COH_SM)) begin
				err = 1'b1;
			end else if (is_pr) begin
				stamp_we = 1'b1;
				priority if (st == COH_I) begin
					r0  = REQ_RD;
					cls = item.shared ? CLS_SHARED : CLS_PRIVATE;
					if (is_rd) begin
						nst = item.shared ? COH_SC : COH_E;
					end else if (item.shared) begin
						r1  = REQ_UPD;
						nst = COH_SM;
					end else begin
						nst = COH_M;
					end
				end else if (st == COH_SC || st == COH_SM) begin
					if (is_wr) begin
						r0  = REQ_UPD;
						nst = item.shared ? COH_SM : COH_M;
					end
					cls = CLS_SHARED;
				end else begin
					if (is_wr) begin
						nst = COH_M;
					end
					cls = CLS_PRIVATE;
				end
			end else if (st != COH_I && item.func != EV_BUS_RDX) begin
				if (item.func == EV_BUS_RD) begin
					if (st == COH_E) begin
						nst = COH_SC;
					end else if (st == COH_M) begin
						nst = COH_SM;
					end
				end else begin
					if (st == COH_SM) begin
						nst = COH_SC;
					end else if (st == COH_E || st == COH_M) begin
						err = 1'b1;
					end
				end
			end
		end

		if (step) begin
			row_new[tgt].coh = nst;
		end
		if (stamp_we) begin
			row_new[tgt].stamp = item.now;
		end
	end

	// ordered result list: flush first, then the protocol requests
	always_comb begin
		res.hit  = hit_any && (is_pr || is_snoop);
		res.cls  = is_pr ? cls : CLS_NONE;
		res.err  = err;
		res.core = core;
		res.req  = {MAX_RESULTS{REQ_NONE}};
		res.addr = '0;
		n        = '0;
		if (flush) begin
			res.req[RES_IDX_BITS'(n)]  = REQ_FLUSH;
			res.addr[RES_IDX_BITS'(n)] = flush_addr;
			n = n + 1'b1;
		end
		if (r0 != REQ_NONE) begin
			res.req[RES_IDX_BITS'(n)]  = r0;
			res.addr[RES_IDX_BITS'(n)] = line_addr;
			n = n + 1'b1;
		end
		if (r1 != REQ_NONE) begin
			res.req[RES_IDX_BITS'(n)]  = r1;
			res.addr[RES_IDX_BITS'(n)] = line_addr;
			n = n + 1'b1;
		end
		if (n == '0) begin
			n = RES_CNT_BITS'(1);
		end
		res.cnt = n;
	end

endmodule

`default_nettype wire

[hw/rtl/scc_result_queue.sv]
// holds the results of one request and hands them out one per handshake
`timescale 1ns / 1ps
`default_nettype none

module scc_result_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  scc_pkg::result_set_t res,
	output logic                 free,
	scc_out_if.source            out_ch
);
	import scc_pkg::*;

	result_set_t             set_q;
	logic [RES_CNT_BITS-1:0] cnt_q;
	logic [RES_IDX_BITS-1:0] idx_q;
	logic                    pop;
	logic                    at_last;
	req_t                    cur_req;

	assign at_last = RES_CNT_BITS'(idx_q) == cnt_q - 1'b1;
	assign pop     = out_ch.valid && out_ch.ready;
	// room for a new set when empty or once the last pending result leaves
	assign free    = (cnt_q == '0) || (pop && at_last);

	always_ff @(posedge clk) begin
		if (load) begin
			set_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
			idx_q <= '0;
		end else if (pop && at_last) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign cur_req = set_q.req[idx_q];

	assign out_ch.valid        = cnt_q != '0;
	assign out_ch.hit          = set_q.hit;
	assign out_ch.access_class = set_q.cls;
	assign out_ch.error        = set_q.err;
	assign out_ch.bus_request  = cur_req;
	assign out_ch.bus_address  = set_q.addr[idx_q];
	assign out_ch.bus_cycles   = cost_of(cur_req);
	assign out_ch.request_core = set_q.core;
	assign out_ch.last         = at_last;

endmodule

`default_nettype wire

[hw/rtl/snooping_cache_coherence_controller_top.sv]
// top level of the snooping MESI / Dragon cache coherence controller
//
//   channel   direction  handshake       payload
//   in_ch     in         valid / ready   func, address, shared_line, now_time
//   out_ch    out        valid / ready   hit, access_class, error, bus_request,
//                                        bus_address, bus_cycles, request_core, last
//   cfg       in         cfg_we          cfg_index, cfg_data
//
// a request reads its set from the line store in the accept cycle; the
// registered row is updated in the calc state and written back once the
// result queue is free; the store has a single read and a single write port
// a sink stall holds the write-back of the following request until the
// result queue drains
// reset clears all set valid bits at once: no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module snooping_cache_coherence_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	scc_in_if.sink                              in_ch,
	scc_out_if.source                           out_ch,
	input  logic                                cfg_we,
	input  scc_pkg::cfg_idx_t                   cfg_index,
	input  logic [scc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import scc_pkg::*;

	proto_t               proto_q;
	logic [CORE_BITS-1:0] core_q;
	fsm_t                 state_q;
	fsm_t                 state_d;
	item_t                item_q;
	logic                 accept;
	logic                 q_free;
	logic                 commit;
	store_rd_t            rd;
	store_wr_t            wr;
	row_t                 rdata;
	row_t                 row_new;
	result_set_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q <= PROTO_MESI;
			core_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROTOCOL: proto_q <= proto_t'(cfg_data[0]);
				CFG_CORE:     core_q  <= cfg_data[CORE_BITS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.func   <= in_ch.func;
			item_q.tag    <= in_ch.address[ADDR_BITS-1 -: TAG_BITS];
			item_q.set    <= in_ch.address[OFFSET_BITS +: SET_BITS];
			item_q.shared <= in_ch.shared_line;
			item_q.now    <= in_ch.now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (in_ch.valid) state_d = FSM_CALC;
			FSM_CALC: if (q_free) state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = state_q == FSM_IDLE;
		accept      = in_ch.valid && in_ch.ready;
		// write-back waits until the previous results are out
		commit      = state_q == FSM_CALC && q_free;
		rd.en       = accept;
		rd.set      = in_ch.address[OFFSET_BITS +: SET_BITS];
		wr.en       = commit;
		wr.set      = item_q.set;
		wr.row      = row_new;
	end

	scc_line_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.wr     (wr),
		.rdata  (rdata)
	);

	scc_update u_update (
		.item    (item_q),
		.row     (rdata),
		.proto   (proto_q),
		.core    (core_q),
		.row_new (row_new),
		.res     (res)
	);

	scc_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (commit),
		.res    (res),
		.free   (q_free),
		.out_ch (out_ch)
	);

	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == FSM_CALC && !in_ch.ready))
		else $error("request accepted without moving to update");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.bus_request == REQ_NONE) |-> out_ch.last)
		else $error("result without bus request is not the final one");

	a_flush_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.bus_request == REQ_FLUSH) |-> !out_ch.hit)
		else $error("victim flush reported on a hit");

	a_commit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready && !out_ch.last) |-> !commit)
		else $error("write-back while results still pending");

endmodule

`default_nettype wire

[verif/scc_checker.sv]
// checker for the coherence controller: predicts bus results per request and compares them in order
`timescale 1ns / 1ps

module scc_checker
	import scc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	scc_in_if                        req_ch,
	scc_out_if                       res_ch,
	input  logic                     cfg_we,
	input  cfg_idx_t                 cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       mismatches,
	output int                       pending,
	output int                       requests_seen,
	output int                       results_seen
);

	typedef struct packed {
		logic                 hit;
		cls_t                 cls;
		logic                 err;
		req_t                 req;
		logic [ADDR_BITS-1:0] addr;
		logic [COST_BITS-1:0] cycles;
		logic [CORE_BITS-1:0] core;
		logic                 last;
	} bus_result_t;

	localparam int UPD_COST_RAW = (LINE_BYTES / WORD_BYTES) * 2;
	localparam logic [COST_BITS-1:0] UPD_COST =
		(UPD_COST_RAW > 127) ? 7'd127 : COST_BITS'(UPD_COST_RAW);
	localparam logic [COST_BITS-1:0] BASE_COST = 7'd100;

	proto_t                protocol;
	logic [CORE_BITS-1:0]  core_id;
	logic [TAG_BITS-1:0]   way_tag   [SETS*WAYS];
	coh_t                  way_state [SETS*WAYS];
	logic [STAMP_BITS-1:0] way_stamp [SETS*WAYS];
	bus_result_t           expected_q[$];

	function automatic logic [COST_BITS-1:0] bus_cost(input req_t q);
		if (q == REQ_NONE)
			return '0;
		if (q == REQ_UPD)
			return UPD_COST;
		return BASE_COST;
	endfunction

	// states that exist in the protocol now selected
	function automatic logic state_legal(input coh_t s);
		if (protocol == PROTO_MESI)
			return s inside {COH_I, COH_S, COH_M, COH_E};
		return s inside {COH_I, COH_M, COH_E, COH_SC, COH_SM};
	endfunction

	function automatic void predict_request(input logic [2:0] fn,
			input logic [ADDR_BITS-1:0] a, input logic sh, input logic [STAMP_BITS-1:0] now);
		logic [TAG_BITS-1:0]  tg;
		logic [SET_BITS-1:0]  st;
		logic [ADDR_BITS-1:0] line_addr;
		logic [ADDR_BITS-1:0] flush_addr;
		logic                 flush;
		logic                 hit;
		logic                 err;
		cls_t                 cls;
		coh_t                 cur;
		int                   base;
		int                   found;
		int                   victim;
		int                   e;
		req_t                 reqs[$];
		bus_result_t          outs[$];
		bus_result_t          r;

		tg = a[ADDR_BITS-1 -: TAG_BITS];
		st = a[OFFSET_BITS +: SET_BITS];
		line_addr = {a[ADDR_BITS-1:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
		base = int'(st) * WAYS;
		found = -1;
		hit = 1'b0;
		err = 1'b0;
		flush = 1'b0;
		flush_addr = '0;
		cls = CLS_NONE;
		for (int w = 0; w < WAYS; w++)
			if (found < 0 && way_state[base+w] != COH_I && way_tag[base+w] == tg)
				found = w;

		if (fn > EV_BUS_UPD) begin
			err = 1'b1;
		end else if (fn <= EV_PR_WR) begin
			if (found >= 0) begin
				hit = 1'b1;
			end else begin
				// first invalid way, else oldest stamp with the lower way winning ties
				victim = -1;
				for (int w = 0; w < WAYS; w++)
					if (victim < 0 && way_state[base+w] == COH_I)
						victim = w;
				if (victim < 0) begin
					victim = 0;
					for (int w = 1; w < WAYS; w++)
						if (way_stamp[base+w] < way_stamp[base+victim])
							victim = w;
				end
				e = base + victim;
				if (way_state[e] != COH_I) begin
					flush = 1'b1;
					flush_addr = {way_tag[e], st, {OFFSET_BITS{1'b0}}};
					way_state[e] = COH_I;
				end
				way_tag[e] = tg;
				found = victim;
			end
			e = base + found;
			cur = way_state[e];
			if (!state_legal(cur)) begin
				err = 1'b1;
			end else begin
				if (protocol == PROTO_MESI) begin
					case (cur)
						COH_I: begin
							if (fn == EV_PR_RD) begin
								reqs.push_back(REQ_RD);
								way_state[e] = sh ? COH_S : COH_E;
								cls = sh ? CLS_SHARED : CLS_PRIVATE;
							end else begin
								reqs.push_back(REQ_RDX);
								way_state[e] = COH_M;
								cls = CLS_PRIVATE;
							end
						end
						COH_S: begin
							if (fn == EV_PR_WR) begin
								reqs.push_back(REQ_RDX);
								way_state[e] = COH_M;
							end
							cls = CLS_SHARED;
						end
						default: begin
							if (fn == EV_PR_WR)
								way_state[e] = COH_M;
							cls = CLS_PRIVATE;
						end
					endcase
				end else begin
					case (cur)
						COH_I: begin
							reqs.push_back(REQ_RD);
							if (fn == EV_PR_RD) begin
								way_state[e] = sh ? COH_SC : COH_E;
							end else if (sh) begin
								reqs.push_back(REQ_UPD);
								way_state[e] = COH_SM;
							end else begin
								way_state[e] = COH_M;
							end
							cls = sh ? CLS_SHARED : CLS_PRIVATE;
						end
						COH_SC, COH_SM: begin
							if (fn == EV_PR_WR) begin
								reqs.push_back(REQ_UPD);
								way_state[e] = sh ? COH_SM : COH_M;
							end
							cls = CLS_SHARED;
						end
						default: begin
							if (fn == EV_PR_WR)
								way_state[e] = COH_M;
							cls = CLS_PRIVATE;
						end
					endcase
				end
				way_stamp[e] = now;
			end
		end else if (found >= 0) begin
			// snooped request on a line we hold
			hit = 1'b1;
			e = base + found;
			cur = way_state[e];
			if (!state_legal(cur)) begin
				err = 1'b1;
			end else if (protocol == PROTO_MESI) begin
				if (fn == EV_BUS_RD)
					way_state[e] = COH_S;
				else if (fn == EV_BUS_RDX)
					way_state[e] = COH_I;
				else if (cur == COH_S)
					err = 1'b1;
			end else if (fn == EV_BUS_RD) begin
				if (cur == COH_E)
					way_state[e] = COH_SC;
				else if (cur == COH_M)
					way_state[e] = COH_SM;
			end else if (fn == EV_BUS_UPD) begin
				if (cur == COH_SM)
					way_state[e] = COH_SC;
				else if (cur == COH_E || cur == COH_M)
					err = 1'b1;
			end
		end

		r = '0;
		r.hit = hit;
		r.cls = cls;
		r.err = err;
		r.core = core_id;
		if (flush) begin
			r.req = REQ_FLUSH;
			r.addr = flush_addr;
			r.cycles = bus_cost(REQ_FLUSH);
			outs.push_back(r);
		end
		foreach (reqs[k]) begin
			r.req = reqs[k];
			r.addr = line_addr;
			r.cycles = bus_cost(reqs[k]);
			outs.push_back(r);
		end
		if (outs.size() == 0) begin
			r.req = REQ_NONE;
			r.addr = '0;
			r.cycles = '0;
			outs.push_back(r);
		end
		outs[outs.size()-1].last = 1'b1;
		foreach (outs[k])
			expected_q.push_back(outs[k]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_result_t got;
		bus_result_t want;
		logic        bad;

		if (!arst_n) begin
			protocol = PROTO_MESI;
			core_id = '0;
			foreach (way_state[i]) begin
				way_state[i] = COH_I;
				way_tag[i] = '0;
				way_stamp[i] = '0;
			end
			expected_q.delete();
			mismatches = 0;
			requests_seen = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROTOCOL: protocol = proto_t'(cfg_data[0]);
					CFG_CORE:     core_id = cfg_data[CORE_BITS-1:0];
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				predict_request(req_ch.func, req_ch.address, req_ch.shared_line, req_ch.now_time);
				requests_seen++;
			end
			if (res_ch.valid && res_ch.ready) begin
				got.hit = res_ch.hit;
				got.cls = cls_t'(res_ch.access_class);
				got.err = res_ch.error;
				got.req = req_t'(res_ch.bus_request);
				got.addr = res_ch.bus_address;
				got.cycles = res_ch.bus_cycles;
				got.core = res_ch.request_core;
				got.last = res_ch.last;
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request pending: req %0d addr %h",
							$time, got.req, got.addr);
				end else begin
					want = expected_q.pop_front();
					bad = (got.hit !== want.hit) || (got.cls !== want.cls) ||
						(got.err !== want.err) || (got.req !== want.req) ||
						(got.addr !== want.addr) || (got.cycles !== want.cycles) ||
						(got.core !== want.core) || (got.last !== want.last);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp hit %0b cls %0d err %0b req %0d addr %h cyc %0d core %0d last %0b",
								$time, want.hit, want.cls, want.err, want.req, want.addr,
								want.cycles, want.core, want.last);
							$display("          got hit %0b cls %0d err %0b req %0d addr %h cyc %0d core %0d last %0b",
								got.hit, got.cls, got.err, got.req, got.addr,
								got.cycles, got.core, got.last);
						end
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

[verif/snooping_cache_coherence_controller_top_tb.sv]
// testbench top: drives requests and register writes into the coherence controller and gives the verdict
`timescale 1ns / 1ps

module snooping_cache_coherence_controller_top_tb;
	import scc_pkg::*;

	localparam int SRC_SIDE = 0;
	localparam int SNK_SIDE = 1;
	localparam int PHASE_REQUESTS = 51;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	cfg_idx_t                 cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       mismatches;
	int                       pending;
	int                       requests_seen;
	int                       results_seen;
	int                       settings_run;
	int                       quiet_run[2];
	logic [STAMP_BITS-1:0]    stamp_clock;

	scc_in_if  req_ch();
	scc_out_if res_ch();

	snooping_cache_coherence_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (req_ch),
		.out_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	scc_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_ch        (req_ch),
		.res_ch        (res_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.requests_seen (requests_seen),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("Simulation FAILED");
		$finish;
	end

	// idle cycles before the next request or result, with runs of back-to-back traffic
	function automatic int draw_wait(input int side);
		if (quiet_run[side] > 0) begin
			quiet_run[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			quiet_run[side] = $urandom_range(6, 24);
		return $urandom_range(0, 4);
	endfunction

	function automatic logic [ADDR_BITS-1:0] line_address(input logic [TAG_BITS-1:0] t,
			input logic [SET_BITS-1:0] s, input logic [OFFSET_BITS-1:0] o);
		return {t, s, o};
	endfunction

	// a few hot sets and tags so lines hit, conflict and get evicted
	function automatic logic [ADDR_BITS-1:0] pick_address();
		logic [TAG_BITS-1:0] t;
		logic [SET_BITS-1:0] s;
		if ($urandom_range(0, 9) < 2)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       t = '0;
			1:       t = TAG_BITS'(1);
			2:       t = TAG_BITS'(2);
			default: t = '1;
		endcase
		case ($urandom_range(0, 3))
			0:       s = '0;
			1:       s = SET_BITS'(1);
			2:       s = '1;
			default: s = SET_BITS'($urandom);
		endcase
		return line_address(t, s, OFFSET_BITS'($urandom));
	endfunction

	task automatic send_request(input logic [2:0] fn, input logic [ADDR_BITS-1:0] a,
			input logic sh, input logic [STAMP_BITS-1:0] now);
		int gap;
		gap = draw_wait(SRC_SIDE);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.address <= a;
		req_ch.shared_line <= sh;
		req_ch.now_time <= now;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// registers change only once every result is out
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input proto_t p, input logic [CORE_BITS-1:0] c);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PROTOCOL;
		cfg_data <= CFG_DATA_BITS'(p);
		@(negedge clk);
		cfg_index <= CFG_CORE;
		cfg_data <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// result sink with random stalls
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = draw_wait(SNK_SIDE);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [ADDR_BITS-1:0] a_line;
		logic [ADDR_BITS-1:0] b_line;
		logic [ADDR_BITS-1:0] c_line;
		logic [ADDR_BITS-1:0] d_line;
		logic [ADDR_BITS-1:0] e_line;
		logic [STAMP_BITS-1:0] now;
		logic [2:0] fn;
		int pick;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PROTOCOL;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.address = '0;
		req_ch.shared_line = 1'b0;
		req_ch.now_time = '0;
		quiet_run = '{0, 0};
		stamp_clock = '0;
		settings_run = 0;
		a_line = line_address('0, '0, '0);
		b_line = line_address(TAG_BITS'(1), '0, '1);
		c_line = line_address('1, '0, OFFSET_BITS'(7));
		d_line = line_address(TAG_BITS'(5), '0, '0);
		e_line = line_address(TAG_BITS'(3), '1, OFFSET_BITS'(3));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		set_mode(PROTO_MESI, '0);

		// mesi walk through one line
		send_request(EV_PR_RD, a_line, 1'b0, 32'd10);
		send_request(EV_PR_WR, a_line, 1'b0, 32'd11);
		send_request(EV_BUS_UPD, a_line, 1'b0, 32'd0);
		send_request(EV_BUS_RD, a_line, 1'b1, 32'd0);
		send_request(EV_BUS_UPD, a_line, 1'b0, 32'd0);
		send_request(EV_PR_WR, a_line, 1'b1, 32'd12);
		send_request(EV_BUS_RDX, a_line, 1'b0, 32'd0);
		send_request(EV_BUS_RD, a_line, 1'b0, '1);
		// equal stamps in a full set, then an eviction
		send_request(EV_PR_WR, a_line, 1'b0, 32'd5);
		send_request(EV_PR_RD, b_line, 1'b1, 32'd5);
		send_request(EV_PR_RD, c_line, 1'b0, '1);
		for (int f = int'(EV_BUS_UPD) + 1; f < 8; f++)
			send_request(3'(f), $urandom, 1'($urandom), $urandom);
		send_request(EV_PR_RD, '1, 1'b1, '0);

		// dragon on lines left in mesi states
		wait_idle();
		set_mode(PROTO_DRAGON, '1);
		send_request(EV_PR_RD, b_line, 1'b0, 32'd20);
		send_request(EV_BUS_RD, b_line, 1'b0, 32'd0);
		send_request(EV_PR_WR, d_line, 1'b1, 32'd21);
		send_request(EV_BUS_UPD, d_line, 1'b0, 32'd0);
		send_request(EV_PR_WR, d_line, 1'b0, 32'd22);
		send_request(EV_BUS_UPD, d_line, 1'b0, 32'd0);
		send_request(EV_BUS_RD, d_line, 1'b1, 32'd0);
		send_request(EV_BUS_RDX, d_line, 1'b0, 32'd0);
		send_request(EV_PR_RD, e_line, 1'b1, 32'd23);
		send_request(EV_PR_WR, e_line, 1'b1, 32'd24);

		// back to mesi with dragon-only states around
		wait_idle();
		set_mode(PROTO_MESI, CORE_BITS'(2));
		send_request(EV_BUS_RD, d_line, 1'b0, 32'd0);
		send_request(EV_PR_WR, e_line, 1'b0, 32'd25);

		stamp_clock = 32'd100;
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			set_mode((ph % 2 == 0) ? PROTO_DRAGON : PROTO_MESI, CORE_BITS'($urandom_range(0, 3)));
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					fn = $urandom_range(0, 1) ? EV_PR_WR : EV_PR_RD;
				else if (pick < 95)
					fn = 3'($urandom_range(int'(EV_BUS_RD), int'(EV_BUS_UPD)));
				else
					fn = 3'($urandom_range(int'(EV_BUS_UPD) + 1, 7));
				if ($urandom_range(0, 9) == 0) begin
					now = $urandom;
				end else begin
					stamp_clock += $urandom_range(0, 2);
					now = stamp_clock;
				end
				send_request(fn, pick_address(), 1'($urandom), now);
			end
		end

		req_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (10) @(posedge clk);
		$display("run covered %0d requests and %0d bus results over %0d register settings",
			requests_seen, results_seen, settings_run);
		$display("both protocols, all event codes, evictions and random source and sink stalls");
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[snooping_cache_coherence_controller_top.f]
hw/rtl/scc_pkg.sv
hw/rtl/scc_if.sv
hw/rtl/scc_line_store.sv
hw/rtl/scc_update.sv
hw/rtl/scc_result_queue.sv
hw/rtl/snooping_cache_coherence_controller_top.sv
verif/scc_checker.sv
verif/snooping_cache_coherence_controller_top_tb.sv
